/* rtl/scba_pkg.sv */
// scba_pkg: shared types and constants of the size class block allocator
// holds the status codes, the size class tables and the controller to datapath command set
// no dependencies
package scba_pkg;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_LARGE = 3'd1,
      ST_NO_PAGE   = 3'd2,
      ST_NOT_ALLOC = 3'd3,
      ST_SIZE_BAD  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_ACLS,
      CMD_SCAN,
      CMD_THREAD,
      CMD_NEWPG,
      CMD_PGRD,
      CMD_PGLAT,
      CMD_ABRD,
      CMD_AUPD,
      CMD_FCHK,
      CMD_FBRD,
      CMD_FBLK,
      CMD_FREL,
      CMD_WRD,
      CMD_WCHK
   } cmd_type;

   typedef struct packed {
      logic too_large;
      logic head_nil;
      logic scan_hit;
      logic scan_last;
      logic thread_last;
      logic bad_page;
      logic bad_block;
      logic blk_err;
      logic now_full;
      logic at_head;
      logic walk_done;
   } dp_stat_type;

   localparam int NUM_CLASSES = 8;
   localparam logic [13:0] HDR_BYTES = 14'd8;
   localparam logic [6:0] BLK_NIL = 7'd127;
   localparam logic ADDR_MAX_REQ = 1'b0;

   localparam logic [12:0] CLASS_BYTES [NUM_CLASSES] = '{
      13'd32, 13'd64, 13'd128, 13'd252, 13'd508, 13'd1020, 13'd2040, 13'd4080
   };
   localparam logic [6:0] CLASS_BLOCKS [NUM_CLASSES] = '{
      7'd127, 7'd63, 7'd31, 7'd16, 7'd8, 7'd4, 7'd2, 7'd1
   };

endpackage

/* rtl/scba_ctrl.sv */
// scba_ctrl: sequencing state machine of the allocator
// issues one datapath command per cycle and steers on datapath status
// depends on scba_pkg
module scba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_op,
   input  scba_pkg::dp_stat_type stat,
   output scba_pkg::cmd_type     cmd,
   output logic                  busy
);

   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_ACLS   = 16'h0002,
      S_SCAN   = 16'h0004,
      S_THREAD = 16'h0008,
      S_NEWPG  = 16'h0010,
      S_PGRD   = 16'h0020,
      S_PGLAT  = 16'h0040,
      S_ABRD   = 16'h0080,
      S_AUPD   = 16'h0100,
      S_FCHK   = 16'h0200,
      S_FPG    = 16'h0400,
      S_FBRD   = 16'h0800,
      S_FBLK   = 16'h1000,
      S_FREL   = 16'h2000,
      S_WRD    = 16'h4000,
      S_WCHK   = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = scba_pkg::CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd      = scba_pkg::CMD_LOAD;
               state_in = req_op ? S_FCHK : S_ACLS;
            end
         end
         S_ACLS: begin
            cmd = scba_pkg::CMD_ACLS;
            if (stat.too_large) state_in = S_IDLE;
            else if (stat.head_nil) state_in = S_SCAN;
            else state_in = S_PGRD;
         end
         S_SCAN: begin
            cmd = scba_pkg::CMD_SCAN;
            if (stat.scan_hit) state_in = S_THREAD;
            else if (stat.scan_last) state_in = S_IDLE;
         end
         S_THREAD: begin
            cmd = scba_pkg::CMD_THREAD;
            if (stat.thread_last) state_in = S_NEWPG;
         end
         S_NEWPG: begin
            cmd      = scba_pkg::CMD_NEWPG;
            state_in = S_ABRD;
         end
         S_PGRD: begin
            cmd      = scba_pkg::CMD_PGRD;
            state_in = S_PGLAT;
         end
         S_PGLAT: begin
            cmd      = scba_pkg::CMD_PGLAT;
            state_in = S_ABRD;
         end
         S_ABRD: begin
            cmd      = scba_pkg::CMD_ABRD;
            state_in = S_AUPD;
         end
         S_AUPD: begin
            cmd      = scba_pkg::CMD_AUPD;
            state_in = S_IDLE;
         end
         S_FCHK: begin
            cmd      = scba_pkg::CMD_FCHK;
            state_in = stat.bad_page ? S_IDLE : S_FPG;
         end
         S_FPG: begin
            cmd      = scba_pkg::CMD_PGLAT;
            state_in = S_FBRD;
         end
         S_FBRD: begin
            cmd      = scba_pkg::CMD_FBRD;
            state_in = stat.bad_block ? S_IDLE : S_FBLK;
         end
         S_FBLK: begin
            cmd = scba_pkg::CMD_FBLK;
            if (stat.blk_err || !stat.now_full) state_in = S_IDLE;
            else state_in = S_FREL;
         end
         S_FREL: begin
            cmd      = scba_pkg::CMD_FREL;
            state_in = stat.at_head ? S_IDLE : S_WRD;
         end
         S_WRD: begin
            cmd      = scba_pkg::CMD_WRD;
            state_in = S_WCHK;
         end
         S_WCHK: begin
            cmd      = scba_pkg::CMD_WCHK;
            state_in = stat.walk_done ? S_IDLE : S_WRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* rtl/scba_datapath.sv */
// scba_datapath: page and block stores, class list heads and result registers
// carries out one controller command per cycle; page and block records live in memories
// depends on scba_pkg
module scba_datapath #(
   parameter int POOL_PAGES          = 64,
   parameter int MAX_BLOCKS_PER_PAGE = 127
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scba_pkg::cmd_type     cmd,
   output scba_pkg::dp_stat_type stat,
   input  logic [12:0]           max_req,
   input  logic [12:0]           req_request_size,
   input  logic [5:0]            req_page_index,
   input  logic [6:0]            req_block_index,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic [5:0]            rsp_result_page,
   output logic [6:0]            rsp_result_block,
   output logic [2:0]            rsp_size_class,
   output logic                  rsp_page_released
);

   localparam int PGW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;

   typedef struct packed {
      logic [2:0]     cls;
      logic [6:0]     cnt;
      logic [6:0]     head;
      logic           lnil;
      logic [PGW-1:0] link;
   } prec_type;

   typedef struct packed {
      logic        used;
      logic [6:0]  link;
      logic [12:0] len;
   } brec_type;

   function automatic logic [6:0] blocks_of(input logic [2:0] c);
      logic [6:0] cb;
      cb = scba_pkg::CLASS_BLOCKS[c];
      return (32'(cb) > MAX_BLOCKS_PER_PAGE) ? 7'(MAX_BLOCKS_PER_PAGE) : cb;
   endfunction

   prec_type pmem_ff [POOL_PAGES];
   brec_type bmem_ff [POOL_PAGES*128];
   prec_type prd_ff;
   brec_type brd_ff;

   logic [12:0]           size_ff, size_in;
   logic [5:0]            pg_ff, pg_in;
   logic [6:0]            blk_ff, blk_in;
   logic [2:0]            cls_ff, cls_in;
   logic [PGW-1:0]        p_ff, p_in;
   logic [PGW-1:0]        q_ff, q_in;
   logic [6:0]            i_ff, i_in;
   prec_type              pr_ff, pr_in;
   logic [POOL_PAGES-1:0] owned_ff, owned_in;
   logic [7:0]            chnil_ff, chnil_in;
   logic [PGW-1:0]        chpg_ff [8];
   logic [PGW-1:0]        chpg_in [8];

   logic           pwe, pre, bwe, bre;
   logic [PGW-1:0] pwa, pra;
   prec_type       pwd;
   logic [PGW+6:0] bwa, bra;
   brec_type       bwd;

   logic        emit;
   logic [2:0]  e_st, e_cls;
   logic [5:0]  e_pg;
   logic [6:0]  e_blk;
   logic        e_rel;

   logic [13:0] sum_c;
   logic [2:0]  cls_c;
   logic [6:0]  n_cls, n_pr;
   prec_type    npr;

   assign n_cls = blocks_of(cls_ff);
   assign n_pr  = blocks_of(pr_ff.cls);

   always_comb begin
      sum_c = {1'b0, size_ff} + scba_pkg::HDR_BYTES;
      cls_c = 3'd7;
      for (int c = scba_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
         if (sum_c <= {1'b0, scba_pkg::CLASS_BYTES[c]}) cls_c = 3'(c);
      end
   end

   always_comb begin
      size_in  = size_ff;
      pg_in    = pg_ff;
      blk_in   = blk_ff;
      cls_in   = cls_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      i_in     = i_ff;
      pr_in    = pr_ff;
      owned_in = owned_ff;
      chnil_in = chnil_ff;
      chpg_in  = chpg_ff;
      stat     = '0;
      pwe = 1'b0; pre = 1'b0; bwe = 1'b0; bre = 1'b0;
      pwa = p_ff; pra = p_ff; pwd = pr_ff;
      bwa = {p_ff, i_ff}; bra = {p_ff, blk_ff}; bwd = brd_ff;
      emit  = 1'b0;
      e_st  = scba_pkg::ST_OK;
      e_pg  = '0;
      e_blk = '0;
      e_cls = '0;
      e_rel = 1'b0;
      npr   = pr_ff;
      unique case (cmd)
         scba_pkg::CMD_NONE: ;
         scba_pkg::CMD_LOAD: begin
            size_in = req_request_size;
            pg_in   = req_page_index;
            blk_in  = req_block_index;
         end
         scba_pkg::CMD_ACLS: begin
            stat.too_large = (size_ff > max_req) ||
               (sum_c > {1'b0, scba_pkg::CLASS_BYTES[scba_pkg::NUM_CLASSES-1]});
            stat.head_nil = chnil_ff[cls_c];
            cls_in = cls_c;
            q_in   = '0;
            p_in   = chpg_ff[cls_c];
            if (stat.too_large) begin
               emit = 1'b1;
               e_st = scba_pkg::ST_TOO_LARGE;
            end
         end
         scba_pkg::CMD_SCAN: begin
            stat.scan_hit  = !owned_ff[q_ff];
            stat.scan_last = (q_ff == PGW'(POOL_PAGES - 1));
            p_in = q_ff;
            i_in = '0;
            if (!stat.scan_hit) begin
               if (stat.scan_last) begin
                  emit  = 1'b1;
                  e_st  = scba_pkg::ST_NO_PAGE;
                  e_cls = cls_ff;
               end else begin
                  q_in = q_ff + 1'b1;
               end
            end
         end
         scba_pkg::CMD_THREAD: begin
            stat.thread_last = (i_ff == n_cls - 7'd1);
            bwe      = 1'b1;
            bwa      = {p_ff, i_ff};
            bwd.used = 1'b0;
            bwd.link = ((i_ff + 7'd1) < n_cls) ? i_ff + 7'd1 : scba_pkg::BLK_NIL;
            bwd.len  = '0;
            i_in     = i_ff + 7'd1;
         end
         scba_pkg::CMD_NEWPG: begin
            owned_in[p_ff]  = 1'b1;
            pr_in.cls       = cls_ff;
            pr_in.cnt       = n_cls;
            pr_in.head      = '0;
            pr_in.lnil      = chnil_ff[cls_ff];
            pr_in.link      = chpg_ff[cls_ff];
            chnil_in[cls_ff] = 1'b0;
            chpg_in[cls_ff]  = p_ff;
         end
         scba_pkg::CMD_PGRD: begin
            pre = 1'b1;
            pra = p_ff;
         end
         scba_pkg::CMD_PGLAT: pr_in = prd_ff;
         scba_pkg::CMD_ABRD: begin
            bre = 1'b1;
            bra = {p_ff, pr_ff.head};
         end
         scba_pkg::CMD_AUPD: begin
            npr.head = brd_ff.link;
            npr.cnt  = pr_ff.cnt - 7'd1;
            if (npr.cnt == 7'd0) begin
               chnil_in[cls_ff] = pr_ff.lnil;
               chpg_in[cls_ff]  = pr_ff.link;
               npr.lnil         = 1'b1;
            end
            pr_in    = npr;
            pwe      = 1'b1;
            pwa      = p_ff;
            pwd      = npr;
            bwe      = 1'b1;
            bwa      = {p_ff, pr_ff.head};
            bwd.used = 1'b1;
            bwd.link = brd_ff.link;
            bwd.len  = size_ff;
            emit     = 1'b1;
            e_pg     = 6'(p_ff);
            e_blk    = pr_ff.head;
            e_cls    = cls_ff;
         end
         scba_pkg::CMD_FCHK: begin
            stat.bad_page = ({5'd0, pg_ff} >= 11'(POOL_PAGES)) || !owned_ff[PGW'(pg_ff)];
            p_in = PGW'(pg_ff);
            pre  = 1'b1;
            pra  = PGW'(pg_ff);
            if (stat.bad_page) begin
               emit  = 1'b1;
               e_st  = scba_pkg::ST_NOT_ALLOC;
               e_pg  = pg_ff;
               e_blk = blk_ff;
            end
         end
         scba_pkg::CMD_FBRD: begin
            stat.bad_block = (blk_ff >= n_pr);
            bre = 1'b1;
            bra = {p_ff, blk_ff};
            if (stat.bad_block) begin
               emit  = 1'b1;
               e_st  = scba_pkg::ST_NOT_ALLOC;
               e_pg  = pg_ff;
               e_blk = blk_ff;
            end
         end
         scba_pkg::CMD_FBLK: begin
            cls_in   = pr_ff.cls;
            npr.head = blk_ff;
            npr.cnt  = pr_ff.cnt + 7'd1;
            if (npr.cnt == 7'd1) begin
               npr.lnil = chnil_ff[pr_ff.cls];
               npr.link = chpg_ff[pr_ff.cls];
            end
            stat.now_full = (npr.cnt >= n_pr);
            e_pg  = pg_ff;
            e_blk = blk_ff;
            if (!brd_ff.used) begin
               stat.blk_err = 1'b1;
               emit         = 1'b1;
               e_st         = scba_pkg::ST_NOT_ALLOC;
            end else if (size_ff != 13'd0 && size_ff != brd_ff.len) begin
               stat.blk_err = 1'b1;
               emit         = 1'b1;
               e_st         = scba_pkg::ST_SIZE_BAD;
               e_cls        = pr_ff.cls;
            end else begin
               if (npr.cnt == 7'd1) begin
                  chnil_in[pr_ff.cls] = 1'b0;
                  chpg_in[pr_ff.cls]  = p_ff;
               end
               pr_in    = npr;
               bwe      = 1'b1;
               bwa      = {p_ff, blk_ff};
               bwd.used = 1'b0;
               bwd.link = pr_ff.head;
               bwd.len  = brd_ff.len;
               if (!stat.now_full) begin
                  pwe   = 1'b1;
                  pwa   = p_ff;
                  pwd   = npr;
                  emit  = 1'b1;
                  e_cls = pr_ff.cls;
               end
            end
         end
         scba_pkg::CMD_FREL: begin
            stat.at_head = !chnil_ff[cls_ff] && (chpg_ff[cls_ff] == p_ff);
            q_in = chpg_ff[cls_ff];
            if (stat.at_head) begin
               chnil_in[cls_ff] = pr_ff.lnil;
               chpg_in[cls_ff]  = pr_ff.link;
               owned_in[p_ff]   = 1'b0;
               emit  = 1'b1;
               e_pg  = pg_ff;
               e_blk = blk_ff;
               e_cls = cls_ff;
               e_rel = 1'b1;
            end
         end
         scba_pkg::CMD_WRD: begin
            pre = 1'b1;
            pra = q_ff;
         end
         scba_pkg::CMD_WCHK: begin
            stat.walk_done = prd_ff.lnil || (prd_ff.link == p_ff);
            q_in = prd_ff.link;
            if (stat.walk_done) begin
               if (!prd_ff.lnil) begin
                  pwe      = 1'b1;
                  pwa      = q_ff;
                  pwd      = prd_ff;
                  pwd.lnil = pr_ff.lnil;
                  pwd.link = pr_ff.link;
               end
               owned_in[p_ff] = 1'b0;
               emit  = 1'b1;
               e_pg  = pg_ff;
               e_blk = blk_ff;
               e_cls = cls_ff;
               e_rel = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pwe) pmem_ff[pwa] <= pwd;
      if (pre) prd_ff <= pmem_ff[pra];
      if (bwe) bmem_ff[bwa] <= bwd;
      if (bre) brd_ff <= bmem_ff[bra];
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      pg_ff   <= pg_in;
      blk_ff  <= blk_in;
      cls_ff  <= cls_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      i_ff    <= i_in;
      pr_ff   <= pr_in;
      chpg_ff <= chpg_in;
      if (emit) begin
         rsp_status        <= e_st;
         rsp_result_page   <= e_pg;
         rsp_result_block  <= e_blk;
         rsp_size_class    <= e_cls;
         rsp_page_released <= e_rel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owned_ff  <= '0;
         chnil_ff  <= '1;
         rsp_valid <= 1'b0;
      end else begin
         owned_ff  <= owned_in;
         chnil_ff  <= chnil_in;
         rsp_valid <= emit;
      end
   end

endmodule

/* rtl/size_class_block_allocator.sv */
// size class block allocator: an allocate from a page already on its class list reads the page record
// and the head block, then updates both; a new page is found by a pool scan and its blocks are threaded first
// a free checks the page, reads the block and frees it; a free that leaves all blocks of its page free
// releases the page; the page and block memories have one read port each; one word at a time
// the word shows on the rsp ports with rsp_valid high for one cycle, as busy falls; the receiver cannot stall
// reset (synchronous) empties the pool and the class lists at once; no clearing pass
module size_class_block_allocator #(
   parameter int POOL_PAGES          = 64,
   parameter int MAX_BLOCKS_PER_PAGE = 127
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [12:0] req_request_size,
   input  logic [5:0]  req_page_index,
   input  logic [6:0]  req_block_index,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_result_page,
   output logic [6:0]  rsp_result_block,
   output logic [2:0]  rsp_size_class,
   output logic        rsp_page_released,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   scba_pkg::cmd_type     cmd;
   scba_pkg::dp_stat_type stat;
   logic [12:0]           max_ff, max_in;

   always_comb begin
      max_in = max_ff;
      if (psel && penable && pwrite && paddr[2] == scba_pkg::ADDR_MAX_REQ) max_in = pwdata[12:0];
   end

   always_ff @(posedge clock) begin
      if (reset) max_ff <= 13'd4096;
      else max_ff <= max_in;
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == scba_pkg::ADDR_MAX_REQ) ? {19'd0, max_ff} : 32'd0;

   scba_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   scba_datapath #(
      .POOL_PAGES          (POOL_PAGES),
      .MAX_BLOCKS_PER_PAGE (MAX_BLOCKS_PER_PAGE)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .max_req           (max_ff),
      .req_request_size  (req_request_size),
      .req_page_index    (req_page_index),
      .req_block_index   (req_block_index),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_result_page   (rsp_result_page),
      .rsp_result_block  (rsp_result_block),
      .rsp_size_class    (rsp_size_class),
      .rsp_page_released (rsp_page_released)
   );

endmodule

/* rtl/scba_checker.sv */
// scba_checker: port level checks of the size class block allocator
// bound to the top level; depends on scba_pkg
module scba_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [2:0] rsp_status,
   input logic [5:0] rsp_result_page,
   input logic [6:0] rsp_result_block,
   input logic [2:0] rsp_size_class,
   input logic       rsp_page_released
);

   a_idle_after_reset: assert property (@(posedge clock) reset |=> !busy)
      else $error("busy right after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_word_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without work");

   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_page_released |-> rsp_status == scba_pkg::ST_OK)
      else $error("page released on a failed free");

   a_too_large_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == scba_pkg::ST_TOO_LARGE |->
         rsp_result_page == 6'd0 && rsp_result_block == 7'd0 && rsp_size_class == 3'd0)
      else $error("refused request carries a block");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (.*);
